/* hw/rtl/fcpw_pkg.sv */
// Shared constants and the channel quantiser function for the fragment pack writer.
package fcpw_pkg;
    localparam int COORD_BITS_DEF = 14;
    localparam int WIDTH_BITS     = 15;
    localparam logic [0:0] REG_FRAME_WIDTH = 1'b0;
    localparam logic [0:0] REG_COLOR_BASE  = 1'b1;

    // Float channel to unorm8: truncation of round-to-nearest-even(c*255).
    function automatic logic [7:0] quantize(input logic [31:0] bits);
        logic [7:0]  expo;
        logic [23:0] mant;
        logic [31:0] prod;
        logic [31:0] rnd;
        logic [8:0]  sh;
        logic [31:0] q;
        expo = bits[30:23];
        mant = {1'b1, bits[22:0]};
        prod = {8'd0, mant} * 32'd255;
        rnd  = prod;
        if (prod[31]) begin
            // 32-bit product: keep 24 significant bits, round to nearest even on 8
            if (prod[7] && (prod[6:0] != 7'd0 || prod[8]))
                rnd = {prod[31:8], 8'd0} + 32'd256;
            else
                rnd = {prod[31:8], 8'd0};
        end else begin
            if (prod[6] && (prod[5:0] != 6'd0 || prod[7]))
                rnd = {prod[31:7], 7'd0} + 32'd128;
            else
                rnd = {prod[31:7], 7'd0};
        end
        // value = rnd * 2^(expo-150); shift right by 150-expo
        sh = 9'd150 - {1'b0, expo};
        q  = (sh > 9'd31) ? 32'd0 : (rnd >> sh[4:0]);
        if (bits[31])
            quantize = 8'd0;
        else if (expo == 8'hFF)
            quantize = (bits[22:0] != 23'd0) ? 8'd0 : 8'd255;
        else if (bits >= 32'h3F80_0000)
            quantize = 8'd255;
        else if (expo == 8'd0)
            quantize = 8'd0;
        else if (q > 32'd255)
            quantize = 8'd255;
        else
            quantize = q[7:0];
    endfunction
endpackage

/* hw/rtl/fcpw_cfg_regs.sv */
// Configuration register file: frame width and colour buffer base.
module fcpw_cfg_regs import fcpw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [0:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output logic [WIDTH_BITS-1:0] frame_width,
    output logic [31:0]           color_base_word
);
    logic [WIDTH_BITS-1:0] width_reg;
    logic [31:0]           base_reg;

    assign frame_width     = width_reg;
    assign color_base_word = base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_BITS'(1);
            base_reg  <= 32'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH: width_reg <= cfg_data[WIDTH_BITS-1:0];
                REG_COLOR_BASE:  base_reg  <= cfg_data;
                default: ;
            endcase
        end
    end
endmodule

/* hw/rtl/fragment_color_pack_writer_core.sv */
// Fragment colour pack writer: one fragment per unstalled clock, one registered result
// stage. One transaction is accepted every unstalled cycle; each result appears in the
// cycle after its fragment is taken, from a single output register that the whole path
// feeds. With m_ready held high the throughput is one pixel per clock; s_ready follows
// m_ready whenever the output register is full. Configuration writes are always accepted.
module fragment_color_pack_writer_core import fcpw_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [63:0]           cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_pos_x,
    input  logic [COORD_BITS-1:0] s_pos_y,
    input  logic [31:0]           s_red_bits,
    input  logic [31:0]           s_green_bits,
    input  logic [31:0]           s_blue_bits,
    input  logic [31:0]           s_alpha_bits,
    input  logic                  s_last_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_pixel_address,
    output logic [31:0]           m_pixel_word,
    output logic                  m_last_out
);
    logic [WIDTH_BITS-1:0] frame_width;
    logic [31:0]           color_base_word;
    logic                  cfg_hit;
    logic                  valid_reg;
    logic [31:0]           addr_reg, word_reg;
    logic                  last_reg;
    logic [31:0]           addr_next, word_next;

    // indexes beyond the list are accepted and dropped
    assign cfg_hit = cfg_valid && (cfg_index[63:1] == 63'd0);

    fcpw_cfg_regs u_cfg (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_hit),
        .cfg_index(cfg_index[0:0]), .cfg_data(cfg_data),
        .frame_width(frame_width), .color_base_word(color_base_word)
    );
    assign cfg_ready = 1'b1;

    assign addr_next = color_base_word + 32'(s_pos_y) * 32'(frame_width) + 32'(s_pos_x);
    assign word_next = {quantize(s_alpha_bits), quantize(s_red_bits),
                        quantize(s_green_bits), quantize(s_blue_bits)};

    assign s_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (s_ready) valid_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            addr_reg <= addr_next;
            word_reg <= word_next;
            last_reg <= s_last_in;
        end
    end

    assign m_valid         = valid_reg;
    assign m_pixel_address = addr_reg;
    assign m_pixel_word    = word_reg;
    assign m_last_out      = last_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_word) && $stable(m_pixel_address))
        else $error("result changed while stalled");
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted fragment lost");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("stalled while empty");
endmodule

/* tb/tb_fragment_color_pack_writer_core.sv */
// Testbench for the fragment colour pack writer: directed table, random fragments, predictor check.
`timescale 1ns / 100ps

module tb_fragment_color_pack_writer_core;
    import fcpw_pkg::*;

    localparam int CB = COORD_BITS_DEF;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [31:0]   r;
        logic [31:0]   g;
        logic [31:0]   b;
        logic [31:0]   a;
        logic          last;
    } frag_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] word;
        logic        last;
    } pixel_t;

    // directed row: fragment plus optional typed-in expected pixel word
    typedef struct packed {
        frag_t       f;
        logic        known;
        logic [31:0] word;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [63:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CB-1:0] s_pos_x = '0;
    logic [CB-1:0] s_pos_y = '0;
    logic [31:0] s_red_bits = '0;
    logic [31:0] s_green_bits = '0;
    logic [31:0] s_blue_bits = '0;
    logic [31:0] s_alpha_bits = '0;
    logic s_last_in = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [31:0] m_pixel_address;
    logic [31:0] m_pixel_word;
    logic m_last_out;

    logic [14:0] width_reg;
    logic [31:0] base_reg;
    pixel_t pending_pixels[$];
    int errors = 0;
    bit fill_ready_always = 1'b0;

    always #4 aclk = ~aclk;

    fragment_color_pack_writer_core uut (.*);

    // exact c*255 rounded to a float, then truncated
    function automatic logic [7:0] unorm8(input logic [31:0] v);
        logic [7:0]  e;
        logic [33:0] p;
        logic [33:0] q;
        logic [33:0] rem;
        logic [33:0] half;
        int n;
        int s;
        int sc;
        e = v[30:23];
        if (v[31]) return 8'd0;
        if (e == 8'hFF) return (v[22:0] != 0) ? 8'd0 : 8'd255;
        if (v >= 32'h3F80_0000) return 8'd255;
        if (e == 8'd0) begin
            p = 34'(v[22:0]) * 34'd255;
            sc = -149;
        end else begin
            p = 34'({1'b1, v[22:0]}) * 34'd255;
            sc = int'(e) - 150;
        end
        if (p == 0) return 8'd0;
        n = 0;
        while (n < 34 && (p >> n) != 0) n++;
        if (n > 24) begin
            s = n - 24;
            q = p >> s;
            rem = p & ((34'd1 << s) - 1);
            half = 34'd1 << (s - 1);
            if (rem > half || (rem == half && q[0])) q++;
            p = q << s;
        end
        if (sc >= 0) return 8'd255;
        if (-sc >= 34) return 8'd0;
        q = p >> (-sc);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic pixel_t pack_pixel(input frag_t f);
        pixel_t p;
        p.addr = base_reg + 32'(f.y) * 32'(width_reg) + 32'(f.x);
        p.word = {unorm8(f.a), unorm8(f.r), unorm8(f.g), unorm8(f.b)};
        p.last = f.last;
        return p;
    endfunction

    function automatic logic [31:0] rand_colour();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'h3F80_0000;
            2: return {1'b0, 8'hFF, 23'($urandom_range(0, 1))};
            3: return {9'h0, 23'($urandom())};
            4: return {1'b1, 31'($urandom())};
            default: return {2'b00, 7'($urandom_range(7'h60, 7'h7E)), 23'($urandom())};
        endcase
    endfunction

    // valid stays high across back-to-back transactions; it drops only for a gap or a drain
    task automatic send_frag(input frag_t f, input logic known, input logic [31:0] word);
        pixel_t p;
        int gap;
        gap = $urandom_range(0, 18) * $urandom_range(0, 1);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        p = pack_pixel(f);
        if (known && p.word !== word) begin
            $display("%0t predictor word expected %h actual %h", $time, word, p.word);
            errors++;
        end
        pending_pixels.push_back(p);
        s_valid <= 1'b1;
        {s_pos_x, s_pos_y, s_red_bits, s_green_bits, s_blue_bits, s_alpha_bits, s_last_in} <= f;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [63:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == 64'(REG_FRAME_WIDTH)) width_reg = val[14:0];
        else base_reg = val;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // receiver with random stalls
    always @(posedge aclk) begin
        pixel_t exp_p;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t unexpected pixel addr %h word %h", $time, m_pixel_address,
                         m_pixel_word);
                errors++;
            end else begin
                exp_p = pending_pixels.pop_front();
                if (m_pixel_address !== exp_p.addr) begin
                    $display("%0t address expected %h actual %h", $time, exp_p.addr,
                             m_pixel_address);
                    errors++;
                end
                if (m_pixel_word !== exp_p.word) begin
                    $display("%0t word expected %h actual %h", $time, exp_p.word,
                             m_pixel_word);
                    errors++;
                end
                if (m_last_out !== exp_p.last) begin
                    $display("%0t last expected %b actual %b", $time, exp_p.last,
                             m_last_out);
                    errors++;
                end
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (fill_ready_always) m_ready <= 1'b1;
            else if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = $urandom_range(0, 18);
            end
        end
    end

    row_t rows[] = '{
        '{'{14'd0, 14'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b1, 32'h0000_0000},
        '{'{14'h3FFF, 14'h3FFF, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000,
            32'h3F80_0000, 1'b1}, 1'b1, 32'hFFFF_FFFF},
        '{'{14'd5, 14'd0, 32'h8000_0000, 32'h7F80_0000, 32'h7FC0_0000,
            32'hFFC0_0000, 1'b0}, 1'b1, 32'h0000_FF00},
        '{'{14'd1, 14'd2, 32'h0000_0001, 32'h007F_FFFF, 32'hFF80_0000,
            32'h7F7F_FFFF, 1'b1}, 1'b1, 32'hFF00_0000},
        '{'{14'd3, 14'd4, 32'h3F00_0000, 32'h3F7F_FFFF, 32'h3B80_8081,
            32'h3E80_0000, 1'b0}, 1'b0, 32'h0},
        '{'{14'h2AAA, 14'h1555, 32'h3C00_0000, 32'h3B80_0000, 32'hBF80_0000,
            32'h4000_0000, 1'b1}, 1'b0, 32'h0},
        '{'{14'h1555, 14'h2AAA, 32'h7F80_0001, 32'h3F7F_0000, 32'h3F80_0001,
            32'h0080_0000, 1'b0}, 1'b0, 32'h0}
    };

    initial begin
        frag_t f;
        logic [14:0] widths[4] = '{15'd1, 15'd16384, 15'd0, 15'h7FFF};
        logic [31:0] bases[4] = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678};
        width_reg = 15'd1;
        base_reg = 32'd0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // reset values first, then all four register settings, then a random setting
        foreach (rows[i]) send_frag(rows[i].f, rows[i].known, rows[i].word);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            if (ph < 4) begin
                write_reg(64'(REG_FRAME_WIDTH), 32'(widths[ph]));
                write_reg(64'(REG_COLOR_BASE), bases[ph]);
            end else begin
                write_reg(64'(REG_FRAME_WIDTH), $urandom_range(1, 16384));
                write_reg(64'(REG_COLOR_BASE), $urandom());
            end
            cfg_valid <= 1'b0;
            fill_ready_always = (ph == 2);
            for (int i = 0; i < 90; i++) begin
                f.x = CB'($urandom());
                f.y = CB'($urandom());
                f.r = rand_colour();
                f.g = rand_colour();
                f.b = rand_colour();
                f.a = rand_colour();
                f.last = 1'($urandom_range(0, 1));
                send_frag(f, 1'b0, 32'h0);
            end
            drain();
        end
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

/* fragment_color_pack_writer_core.f */
hw/rtl/fcpw_pkg.sv
hw/rtl/fcpw_cfg_regs.sv
hw/rtl/fragment_color_pack_writer_core.sv
tb/tb_fragment_color_pack_writer_core.sv
